@@ rtl/lc3_instruction_execute_unit_defines.svh @@
// ----------------------------------------------------------------------------
// lc3 execute unit assertion macros
// shared concurrent assertion wrappers
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LC3_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define LC3_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LC3_ASSERT_IMPL(label, clk, rst, prop)
`define LC3_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/lc3_pkg.sv @@
// ----------------------------------------------------------------------------
// lc3 package
// types, codes and helpers for the lc3 execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package lc3_pkg;
   localparam int MEM_ADDR_BITS = 16;
   localparam int WORD_BITS     = 16;

   typedef logic [WORD_BITS-1:0]     word_type;
   typedef logic [MEM_ADDR_BITS-1:0] maddr_type;

   typedef enum logic [1:0] {
      CMD_EXEC  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_SETPC = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_BR   = 4'h0, OP_ADD = 4'h1, OP_LD  = 4'h2, OP_ST   = 4'h3,
      OP_JSR  = 4'h4, OP_AND = 4'h5, OP_LDR = 4'h6, OP_STR  = 4'h7,
      OP_RTI  = 4'h8, OP_NOT = 4'h9, OP_LDI = 4'hA, OP_STI  = 4'hB,
      OP_JMP  = 4'hC, OP_RES = 4'hD, OP_LEA = 4'hE, OP_TRAP = 4'hF
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADDR, ST_IND, ST_DATA, ST_DONE
   } state_type;

   // address source for the memory port
   typedef enum logic [1:0] {
      AS_CALC, AS_RDATA, AS_INPUT
   } asel_type;

   typedef struct packed {
      logic     load;      // capture request
      logic     mem_rd;    // issue read
      logic     mem_wr;    // issue write
      asel_type asel;
      logic     commit;    // update architectural state and result
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      op_type  op;
   } sts_type;

   function automatic logic [2:0] codes_of(input word_type v);
      logic [2:0] c;
      if (v[WORD_BITS-1]) c = 3'b100;
      else if (v == '0)   c = 3'b010;
      else                c = 3'b001;
      return c;
   endfunction
endpackage
`default_nettype wire

@@ rtl/lc3_instruction_execute_unit.sv @@
// ----------------------------------------------------------------------------
// lc3 instruction execute unit
// executes one lc3 instruction or loader command per beat
// ----------------------------------------------------------------------------
// one beat is handled at a time. register ops, branches, jumps, lea, st, str,
// loader write and set-pc pass the addr state; ld, ldr, trap and loader read
// pass addr then data; sti addr then ind; ldi addr, ind and data, set by the
// dependent reads of the single-port synchronous main memory. the next beat is
// accepted in idle, after the result handoff. memory is not cleared at reset.
`default_nettype none
`include "lc3_instruction_execute_unit_defines.svh"
module lc3_instruction_execute_unit import lc3_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [55:0] req_tdata,  // cmd[1:0], instr[17:2], addr[33:18], wdata[49:34]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [55:0] rsp_tdata   // pc_out[15:0], nzp[18:16], reg_written[19],
                                        // reg_index[22:20], reg_value[38:23], read_data[54:39]
);
   ctl_type    ctl;
   sts_type    sts;
   word_type   pc_out, reg_value, read_data;
   logic [2:0] nzp, reg_index;
   logic       reg_written;

   lc3_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .ctl
   );

   lc3_dpath u_dpath (
      .clock, .reset, .ctl, .sts,
      .in_cmd(req_tdata[1:0]), .in_instr(req_tdata[17:2]),
      .in_addr(req_tdata[33:18]), .in_wdata(req_tdata[49:34]),
      .pc_out, .nzp, .reg_written, .reg_index, .reg_value, .read_data
   );

   assign rsp_tdata = {1'b0, read_data, reg_value, reg_index, reg_written, nzp, pc_out};

   `LC3_ASSERT_IMPL(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))
   `LC3_ASSERT_IMPL(a_nzp_onehot, clock, reset, rsp_tvalid |-> $onehot(nzp))
   `LC3_ASSERT_IMPL(a_wr_only_idx, clock, reset,
      (rsp_tvalid && !reg_written) |-> (reg_index == 3'd0))
   `LC3_ASSERT_NORST(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid)
endmodule
`default_nettype wire

@@ rtl/lc3_ctrl.sv @@
// ----------------------------------------------------------------------------
// lc3 controller
// sequences memory accesses and commit for one beat
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_ctrl import lc3_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output      logic    req_tready,
   output      logic    rsp_tvalid,
   input  wire logic    rsp_tready,
   input  wire sts_type sts,
   output      ctl_type ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '{load: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0, asel: AS_CALC, commit: 1'b0};
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_DONE;
            case (sts.cmd)
               CMD_WRITE: begin
                  ctl.asel = AS_INPUT; ctl.mem_wr = 1'b1; ctl.commit = 1'b1;
               end
               CMD_READ: begin
                  ctl.asel = AS_INPUT; ctl.mem_rd = 1'b1; state_in = ST_DATA;
               end
               CMD_SETPC: ctl.commit = 1'b1;
               default: begin
                  case (sts.op)
                     OP_LD, OP_LDR, OP_TRAP: begin
                        ctl.mem_rd = 1'b1; state_in = ST_DATA;
                     end
                     OP_LDI, OP_STI: begin
                        ctl.mem_rd = 1'b1; state_in = ST_IND;
                     end
                     OP_ST, OP_STR: begin
                        ctl.mem_wr = 1'b1; ctl.commit = 1'b1;
                     end
                     default: ctl.commit = 1'b1;
                  endcase
               end
            endcase
         end
         ST_IND: begin
            ctl.asel = AS_RDATA;
            if (sts.op == OP_STI) begin
               ctl.mem_wr = 1'b1; ctl.commit = 1'b1; state_in = ST_DONE;
            end else begin
               ctl.mem_rd = 1'b1; state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            ctl.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/lc3_dpath.sv @@
// ----------------------------------------------------------------------------
// lc3 datapath
// register file, pc, codes, main memory and result register
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_dpath import lc3_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_type     ctl,
   output      sts_type     sts,
   input  wire logic [1:0]  in_cmd,
   input  wire word_type    in_instr,
   input  wire word_type    in_addr,
   input  wire word_type    in_wdata,
   output      word_type    pc_out,
   output      logic [2:0]  nzp,
   output      logic        reg_written,
   output      logic [2:0]  reg_index,
   output      word_type    reg_value,
   output      word_type    read_data
);
   word_type   mem [2**MEM_ADDR_BITS];
   word_type   rf_ff [8];
   word_type   pc_ff, pc_in;
   logic [2:0] cc_ff, cc_in;
   cmd_type    cmd_ff;
   word_type   ins_ff, addr_ff, wdata_ff, rdata_ff;
   word_type   out_pc_ff, out_val_ff, out_rd_ff;
   logic [2:0] out_cc_ff, out_idx_ff, widx;
   logic       out_wr_ff, wr;
   op_type     op;
   word_type   pc1, off9, off6, off11, imm5, opnd2, sr1v, drv, calc_addr, wval;
   word_type   mem_addr;
   logic       setcc;

   assign op    = op_type'(ins_ff[15:12]);
   assign sts   = '{cmd: cmd_ff, op: op};
   assign pc1   = pc_ff + word_type'(1);
   assign off9  = {{7{ins_ff[8]}}, ins_ff[8:0]};
   assign off6  = {{10{ins_ff[5]}}, ins_ff[5:0]};
   assign off11 = {{5{ins_ff[10]}}, ins_ff[10:0]};
   assign imm5  = {{11{ins_ff[4]}}, ins_ff[4:0]};
   assign sr1v  = rf_ff[ins_ff[8:6]];
   assign drv   = rf_ff[ins_ff[11:9]];
   assign opnd2 = ins_ff[5] ? imm5 : rf_ff[ins_ff[2:0]];

   always_comb begin
      case (op)
         OP_LDR, OP_STR: calc_addr = sr1v + off6;
         OP_TRAP:        calc_addr = {8'd0, ins_ff[7:0]};
         default:        calc_addr = pc1 + off9;
      endcase
      case (ctl.asel)
         AS_RDATA: mem_addr = rdata_ff;
         AS_INPUT: mem_addr = addr_ff;
         default:  mem_addr = calc_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) mem[mem_addr[MEM_ADDR_BITS-1:0]] <= (cmd_ff == CMD_WRITE) ? wdata_ff : drv;
      if (ctl.mem_rd) rdata_ff <= mem[mem_addr[MEM_ADDR_BITS-1:0]];
      if (ctl.load) begin
         cmd_ff   <= cmd_type'(in_cmd);
         ins_ff   <= in_instr;
         addr_ff  <= in_addr;
         wdata_ff <= in_wdata;
      end
   end

   always_comb begin
      wr    = 1'b0;
      widx  = 3'd0;
      wval  = '0;
      setcc = 1'b0;
      pc_in = pc_ff;
      case (cmd_ff)
         CMD_SETPC: pc_in = addr_ff;
         CMD_EXEC: begin
            pc_in = pc1;
            case (op)
               OP_ADD: begin wr = 1'b1; widx = ins_ff[11:9]; wval = sr1v + opnd2; setcc = 1'b1; end
               OP_AND: begin wr = 1'b1; widx = ins_ff[11:9]; wval = sr1v & opnd2; setcc = 1'b1; end
               OP_NOT: begin wr = 1'b1; widx = ins_ff[11:9]; wval = ~sr1v; setcc = 1'b1; end
               OP_BR:  if ((ins_ff[11:9] & cc_ff) != 3'd0) pc_in = pc1 + off9;
               OP_JMP: pc_in = sr1v;
               OP_JSR: begin
                  wr = 1'b1; widx = 3'd7; wval = pc1;
                  pc_in = ins_ff[11] ? pc1 + off11 : sr1v;
               end
               OP_LD, OP_LDI, OP_LDR: begin
                  wr = 1'b1; widx = ins_ff[11:9]; wval = rdata_ff; setcc = 1'b1;
               end
               OP_LEA: begin wr = 1'b1; widx = ins_ff[11:9]; wval = pc1 + off9; setcc = 1'b1; end
               OP_TRAP: begin wr = 1'b1; widx = 3'd7; wval = pc1; pc_in = rdata_ff; end
               default: ;
            endcase
         end
         default: ;
      endcase
      cc_in = setcc ? codes_of(wval) : cc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         cc_ff <= 3'b010;
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
      end else if (ctl.commit) begin
         pc_ff <= pc_in;
         cc_ff <= cc_in;
         if (wr) rf_ff[widx] <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         out_pc_ff  <= pc_in;
         out_cc_ff  <= cc_in;
         out_wr_ff  <= wr;
         out_idx_ff <= widx;
         out_val_ff <= wval;
         out_rd_ff  <= (cmd_ff == CMD_READ) ? rdata_ff : '0;
      end
   end

   assign pc_out      = out_pc_ff;
   assign nzp         = out_cc_ff;
   assign reg_written = out_wr_ff;
   assign reg_index   = out_idx_ff;
   assign reg_value   = out_val_ff;
   assign read_data   = out_rd_ff;
endmodule
`default_nettype wire

@@ tb/sv/lc3_instruction_execute_unit_tb.sv @@
// ----------------------------------------------------------------------------
// lc3 instruction execute unit testbench
// drives loader commands and lc3 instructions through the request stream,
// predicts every response from a local copy of the architectural state and
// checks the response stream field by field with random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lc3_instruction_execute_unit_tb;
   import lc3_pkg::*;

   // first member is the highest field of the beat
   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] reg_value;
      logic [2:0]  reg_index;
      logic        reg_written;
      logic [2:0]  nzp;
      logic [15:0] pc_out;
   } lc3_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   logic [15:0]    gpr [8];
   logic [15:0]    pc_q;
   logic [2:0]     cc_q;
   logic [15:0]    mem_model [logic [15:0]];
   lc3_result_type expected_results [$];
   int             error_count;
   longint         cycle_count;

   lc3_instruction_execute_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
      logic [15:0] r;
      r = v;
      for (int i = bits; i < 16; i++) r[i] = v[bits-1];
      return r;
   endfunction

   function automatic logic [2:0] sign_codes(input logic [15:0] v);
      if (v[15]) return 3'b100;
      if (v == 16'h0) return 3'b010;
      return 3'b001;
   endfunction

   function automatic logic [15:0] mem_fetch(input logic [15:0] a);
      if (mem_model.exists(a)) return mem_model[a];
      return 16'h0;
   endfunction

   function automatic bit is_written(input logic [15:0] a);
      return mem_model.exists(a);
   endfunction

   // computes the response of one beat and updates the architectural state
   function automatic lc3_result_type execute_beat(input cmd_type cmd, input logic [15:0] ins,
                                                   input logic [15:0] addr,
                                                   input logic [15:0] wdata);
      lc3_result_type r;
      logic [15:0] npc, off9, opnd2, val;
      logic [2:0]  dr, sr1;
      bit          wr, setcc;
      r = '0;
      wr = 0;
      setcc = 0;
      val = '0;
      dr = ins[11:9];
      sr1 = ins[8:6];
      case (cmd)
         CMD_WRITE: mem_model[addr] = wdata;
         CMD_READ: r.read_data = mem_fetch(addr);
         CMD_SETPC: pc_q = addr;
         default: begin
            npc = pc_q + 16'd1;
            off9 = sext(ins, 9);
            opnd2 = ins[5] ? sext(ins, 5) : gpr[ins[2:0]];
            case (op_type'(ins[15:12]))
               OP_ADD: begin wr = 1; setcc = 1; val = gpr[sr1] + opnd2; end
               OP_AND: begin wr = 1; setcc = 1; val = gpr[sr1] & opnd2; end
               OP_NOT: begin wr = 1; setcc = 1; val = ~gpr[sr1]; end
               OP_BR: if ((ins[11:9] & cc_q) != 3'b000) npc = npc + off9;
               OP_JMP: npc = gpr[sr1];
               OP_JSR: begin
                  wr = 1; dr = 3'd7; val = npc;
                  npc = ins[11] ? npc + sext(ins, 11) : gpr[sr1];
               end
               OP_LD: begin wr = 1; setcc = 1; val = mem_fetch(npc + off9); end
               OP_LDI: begin wr = 1; setcc = 1; val = mem_fetch(mem_fetch(npc + off9)); end
               OP_LDR: begin wr = 1; setcc = 1; val = mem_fetch(gpr[sr1] + sext(ins, 6)); end
               OP_LEA: begin wr = 1; setcc = 1; val = npc + off9; end
               OP_ST: mem_model[npc + off9] = gpr[dr];
               OP_STI: mem_model[mem_fetch(npc + off9)] = gpr[dr];
               OP_STR: mem_model[gpr[sr1] + sext(ins, 6)] = gpr[dr];
               OP_TRAP: begin
                  wr = 1; dr = 3'd7; val = npc;
                  npc = mem_fetch({8'h00, ins[7:0]});
               end
               default: ;
            endcase
            if (!wr) dr = 3'd0;
            if (wr) gpr[dr] = val;
            if (setcc) cc_q = sign_codes(val);
            pc_q = npc;
            r.reg_written = wr;
            r.reg_index = dr;
            r.reg_value = val;
         end
      endcase
      r.pc_out = pc_q;
      r.nzp = cc_q;
      return r;
   endfunction

   // drops valid only when an idle gap follows
   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_beat(input cmd_type cmd, input logic [15:0] ins,
                            input logic [15:0] addr, input logic [15:0] wdata);
      random_gap();
      expected_results.push_back(execute_beat(cmd, ins, addr, wdata));
      req_tdata <= {6'b0, wdata, addr, ins, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic poke(input logic [15:0] a, input logic [15:0] d);
      send_beat(CMD_WRITE, 16'h0, a, d);
   endtask

   // makes sure every word an instruction might read is already written
   task automatic prepare_reads(input logic [15:0] ins);
      logic [15:0] npc, a;
      npc = pc_q + 16'd1;
      case (op_type'(ins[15:12]))
         OP_LD, OP_LDI, OP_STI: begin
            a = npc + sext(ins, 9);
            if (!is_written(a)) poke(a, 16'($urandom));
            if (ins[15:12] == OP_LDI) begin
               a = mem_fetch(a);
               if (!is_written(a)) poke(a, 16'($urandom));
            end
         end
         OP_LDR: begin
            a = gpr[ins[8:6]] + sext(ins, 6);
            if (!is_written(a)) poke(a, 16'($urandom));
         end
         OP_TRAP: begin
            a = {8'h00, ins[7:0]};
            if (!is_written(a)) poke(a, 16'($urandom));
         end
         default: ;
      endcase
   endtask

   task automatic run_instr(input logic [15:0] ins);
      prepare_reads(ins);
      send_beat(CMD_EXEC, ins, 16'($urandom), 16'($urandom));
   endtask

   task automatic test_loader();
      poke(16'h0000, 16'hFFFF);
      poke(16'hFFFF, 16'h0000);
      poke(16'h1234, 16'h8001);
      send_beat(CMD_READ, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_beat(CMD_READ, 16'h0, 16'hFFFF, 16'h0);
      send_beat(CMD_READ, 16'h0, 16'h1234, 16'h0);
      send_beat(CMD_SETPC, 16'h0, 16'hFFFF, 16'h0);
      send_beat(CMD_SETPC, 16'h0, 16'h3000, 16'h0);
   endtask

   task automatic test_opcodes();
      run_instr(16'h103F);  // add r0, r0, #-1
      run_instr(16'h1230);  // add r1, r0, #-16
      run_instr(16'h1440);  // add r2, r1, r0
      run_instr(16'h5660);  // and r3, r1, #0
      run_instr(16'h9BFF);  // not r5, r7
      run_instr(16'h0E01);  // brnzp +1
      run_instr(16'h01FF);  // never branch
      run_instr(16'h2DFF);  // ld r6, -1
      run_instr(16'hA1FE);  // ldi r0
      run_instr(16'h6A7F);  // ldr r5, r1, #-1
      run_instr(16'hEFFF);  // lea r7
      run_instr(16'h3400);  // st
      run_instr(16'hB5FC);  // sti
      run_instr(16'h7460);  // str
      run_instr(16'h4FFF);  // jsr -1
      run_instr(16'h4080);  // jsrr r2
      run_instr(16'hC1C0);  // ret
      run_instr(16'hF0FF);  // trap
      run_instr(16'h8000);  // rti
      run_instr(16'hD000);  // reserved
      send_beat(CMD_SETPC, 16'h0, 16'h0FFF, 16'h0);
   endtask

   task automatic test_random();
      logic [15:0] ins;
      for (int i = 0; i < 660; i++) begin
         case ($urandom_range(0, 9))
            0: poke(16'($urandom), 16'($urandom));
            1: begin
               ins = 16'($urandom);
               if (is_written(ins)) send_beat(CMD_READ, 16'($urandom), ins, 16'($urandom));
               else poke(ins, 16'($urandom));
            end
            2: send_beat(CMD_SETPC, 16'($urandom), 16'($urandom), 16'($urandom));
            default: run_instr(16'($urandom));
         endcase
      end
   endtask

   always @(posedge clock) begin
      lc3_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[54:0];
         if (expected_results.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.pc_out !== want.pc_out)
               $display("%0t pc_out: expected %h, actual %h", $time, want.pc_out, got.pc_out);
            if (got.nzp !== want.nzp)
               $display("%0t nzp: expected %b, actual %b", $time, want.nzp, got.nzp);
            if (got.reg_written !== want.reg_written)
               $display("%0t reg_written: expected %b, actual %b", $time,
                        want.reg_written, got.reg_written);
            if (got.reg_index !== want.reg_index)
               $display("%0t reg_index: expected %0d, actual %0d", $time,
                        want.reg_index, got.reg_index);
            if (got.reg_value !== want.reg_value)
               $display("%0t reg_value: expected %h, actual %h", $time,
                        want.reg_value, got.reg_value);
            if (got.read_data !== want.read_data)
               $display("%0t read_data: expected %h, actual %h", $time,
                        want.read_data, got.read_data);
            if (got !== want) error_count++;
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 19);
      if (reset) rsp_tready <= 1'b1;
      else if (r == 0) rsp_tready <= 1'b0;
      else if (r < 5) rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1000000) begin
         $display("lc3_instruction_execute_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      error_count = 0;
      cycle_count = 0;
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      pc_q = '0;
      cc_q = 3'b010;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_loader();
      test_opcodes();
      test_random();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("lc3_instruction_execute_unit_tb: clean");
      else
         $display("lc3_instruction_execute_unit_tb: errors");
      $finish;
   end
endmodule
`default_nettype wire
